FILE: src/ccx_pkg.sv
// Package with the types, constants and helpers shared by the keystream XOR unit.
package ccx_pkg;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam int unsigned NUM_REGS = 7;
    localparam int unsigned ADDR_W = 6;

    localparam logic [2:0] REG_KEY0 = 3'd0;
    localparam logic [2:0] REG_KEY1 = 3'd1;
    localparam logic [2:0] REG_KEY2 = 3'd2;
    localparam logic [2:0] REG_KEY3 = 3'd3;
    localparam logic [2:0] REG_NONCE_LO = 3'd4;
    localparam logic [2:0] REG_NONCE_HI = 3'd5;
    localparam logic [2:0] REG_INIT_CTR = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FINAL,
        ST_OUT
    } state_t;

    // One quarter-round's four words, in and out of the shared core.
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } quad_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

endpackage

FILE: src/ccx_quarter.sv
// Shared ChaCha quarter-round core, one full quarter-round per use.
module ccx_quarter (
    input  ccx_pkg::quad_t qin,
    output ccx_pkg::quad_t qout
);
    import ccx_pkg::*;

    logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;

    always_comb
    begin
        a1 = qin.a + qin.b;
        d1 = rotl(qin.d ^ a1, 16);
        c1 = qin.c + d1;
        b1 = rotl(qin.b ^ c1, 12);
        a2 = a1 + b1;
        d2 = rotl(d1 ^ a2, 8);
        c2 = c1 + d2;
        b2 = rotl(b1 ^ c2, 7);
        qout.a = a2;
        qout.b = b2;
        qout.c = c2;
        qout.d = d2;
    end

endmodule

FILE: src/ccx_regs.sv
// APB configuration register file for key, nonce and initial counter.
module ccx_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccx_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic [255:0]               key,
    output logic [63:0]                nonce_lo,
    output logic [31:0]                nonce_hi,
    output logic [31:0]                init_ctr
);
    import ccx_pkg::*;

    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] init_ctr_reg;
    logic        wr_en;
    logic [2:0]  idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                key_reg[i] <= '0;
            end
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            init_ctr_reg <= 32'd1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_KEY0:     key_reg[0] <= pwdata;
                REG_KEY1:     key_reg[1] <= pwdata;
                REG_KEY2:     key_reg[2] <= pwdata;
                REG_KEY3:     key_reg[3] <= pwdata;
                REG_NONCE_LO: nonce_lo_reg <= pwdata;
                REG_NONCE_HI: nonce_hi_reg <= pwdata[31:0];
                REG_INIT_CTR: init_ctr_reg <= pwdata[31:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KEY0:     prdata = key_reg[0];
            REG_KEY1:     prdata = key_reg[1];
            REG_KEY2:     prdata = key_reg[2];
            REG_KEY3:     prdata = key_reg[3];
            REG_NONCE_LO: prdata = nonce_lo_reg;
            REG_NONCE_HI: prdata = {32'd0, nonce_hi_reg};
            REG_INIT_CTR: prdata = {32'd0, init_ctr_reg};
            default:      prdata = '0;
        endcase
    end

    assign key      = {key_reg[3], key_reg[2], key_reg[1], key_reg[0]};
    assign nonce_lo = nonce_lo_reg;
    assign nonce_hi = nonce_hi_reg;
    assign init_ctr = init_ctr_reg;

endmodule

FILE: src/stream_cipher_keystream_xor_unit.sv
// Top level of the ChaCha20 keystream XOR unit.
//
// Message bytes enter on data_byte/last_byte with valid_in/stall_in and leave
// as out_byte/out_last with valid_out/stall_out. An item is accepted at an
// edge where valid is high and stall is low; exactly one result per item.
// At the first byte of each 64-byte block the unit builds the state and runs
// the block function on one shared quarter-round core, one quarter-round per
// cycle in the round state, between a load state and a final-add state. Such
// a byte then waits in the out state until the output register is free;
// other bytes go straight to the out state. No new item is taken until the
// current one's result is in the output register. A last byte restarts the
// counter at initial_counter for the next message. Reset clears the position,
// sets the counter source to initial_counter and empties the output register.
// While the receiver stalls, the result holds; one more item may be taken,
// and it waits until the output register is free. Configuration is to be
// written over the APB port (8-byte spacing) while idle; the user must keep to
// this, as the block itself does not enforce it.
module stream_cipher_keystream_xor_unit #(
    parameter int unsigned DOUBLE_ROUNDS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ccx_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    input  logic                       valid_in,
    output logic                       stall_in,
    input  logic [7:0]                 data_byte,
    input  logic                       last_byte,
    output logic                       valid_out,
    input  logic                       stall_out,
    output logic [7:0]                 out_byte,
    output logic                       out_last
);
    import ccx_pkg::*;

    localparam int unsigned STEPS = 8 * DOUBLE_ROUNDS;
    localparam int unsigned STEP_W = $clog2(STEPS);

    logic [255:0] key;
    logic [63:0]  nonce_lo;
    logic [31:0]  nonce_hi;
    logic [31:0]  init_ctr;

    state_t       state_reg, state_next;
    logic [31:0]  w_reg [16];
    logic [31:0]  ks_reg [16];
    logic [31:0]  ctr_reg;
    logic [5:0]   pos_reg;
    logic         start_reg;
    logic [STEP_W-1:0] step_reg;
    logic [7:0]   data_reg;
    logic         last_reg;
    logic         ovalid_reg;
    logic [7:0]   obyte_reg;
    logic         olast_reg;

    logic         in_acc, out_free, emit;
    logic [31:0]  init_w [16];
    logic [31:0]  blk_ctr;
    logic [3:0]   ia, ib, ic, id;
    quad_t        qin, qout;
    logic [31:0]  ks_word;
    logic [7:0]   ks_byte;

    ccx_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .key      (key),
        .nonce_lo (nonce_lo),
        .nonce_hi (nonce_hi),
        .init_ctr (init_ctr)
    );

    assign pready = 1'b1;

    assign out_free = !ovalid_reg || !stall_out;
    assign stall_in = (state_reg != ST_IDLE);
    assign in_acc   = valid_in && (state_reg == ST_IDLE);
    assign emit     = (state_reg == ST_OUT) && out_free;

    assign blk_ctr = start_reg ? init_ctr : ctr_reg;

    always_comb
    begin
        init_w[0]  = SIGMA0;
        init_w[1]  = SIGMA1;
        init_w[2]  = SIGMA2;
        init_w[3]  = SIGMA3;
        for (int i = 0; i < 8; i++)
        begin
            init_w[4 + i] = key[32*i +: 32];
        end
        init_w[12] = ctr_reg;
        init_w[13] = nonce_lo[31:0];
        init_w[14] = nonce_lo[63:32];
        init_w[15] = nonce_hi;
    end

    // Quarter-round word indexes: low two step bits pick the lane, bit 2 picks
    // column versus diagonal.
    always_comb
    begin
        ia = {2'b00, step_reg[1:0]};
        if (!step_reg[2])
        begin
            ib = 4'd4 + {2'b00, step_reg[1:0]};
            ic = 4'd8 + {2'b00, step_reg[1:0]};
            id = 4'd12 + {2'b00, step_reg[1:0]};
        end
        else
        begin
            ib = {2'b01, step_reg[1:0] + 2'd1};
            ic = {2'b10, step_reg[1:0] + 2'd2};
            id = {2'b11, step_reg[1:0] + 2'd3};
        end
    end

    assign qin.a = w_reg[ia];
    assign qin.b = w_reg[ib];
    assign qin.c = w_reg[ic];
    assign qin.d = w_reg[id];

    ccx_quarter u_quarter (
        .qin  (qin),
        .qout (qout)
    );

    assign ks_word = ks_reg[pos_reg[5:2]];
    assign ks_byte = ks_word[8*pos_reg[1:0] +: 8];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = (pos_reg == 6'd0) ? ST_LOAD : ST_OUT;
                end
            end
            ST_LOAD:  state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: state_next = ST_OUT;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ctr_reg    <= 32'd1;
            pos_reg    <= '0;
            start_reg  <= 1'b1;
            step_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && in_acc && pos_reg == 6'd0)
            begin
                ctr_reg   <= blk_ctr;
                start_reg <= 1'b0;
            end
            else if (state_reg == ST_FINAL)
            begin
                ctr_reg <= ctr_reg + 32'd1;
            end
            if (state_reg == ST_LOAD)
            begin
                step_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                step_reg <= step_reg + 1'b1;
            end
            if (emit)
            begin
                ovalid_reg <= 1'b1;
                if (last_reg)
                begin
                    pos_reg   <= '0;
                    start_reg <= 1'b1;
                end
                else
                begin
                    pos_reg <= pos_reg + 6'd1;
                end
            end
            else if (!stall_out)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // The counter register holds the block's counter from load until the
    // final add, which also advances it for the next block.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
        if (state_reg == ST_LOAD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= init_w[i];
            end
        end
        else if (state_reg == ST_ROUND)
        begin
            w_reg[ia] <= qout.a;
            w_reg[ib] <= qout.b;
            w_reg[ic] <= qout.c;
            w_reg[id] <= qout.d;
        end
        if (state_reg == ST_FINAL)
        begin
            for (int i = 0; i < 16; i++)
            begin
                ks_reg[i] <= w_reg[i] + init_w[i];
            end
        end
        if (emit)
        begin
            obyte_reg <= data_reg ^ ks_byte;
            olast_reg <= last_reg;
        end
    end

    assign valid_out = ovalid_reg;
    assign out_byte  = obyte_reg;
    assign out_last  = olast_reg;

    // An item is only taken with the core idle.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> stall_in)
        else $error("item accepted while busy");

    // A new block always follows the load and starts at the first round step.
    a_round_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |=> (state_reg == ST_ROUND && step_reg == '0))
        else $error("round sequence did not start cleanly");

    // A block is built only at byte position zero.
    a_load_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD) |-> (pos_reg == 6'd0))
        else $error("block built mid-block");

    // The output register is not overwritten while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_out && stall_out) |=> (valid_out && $stable(out_byte)))
        else $error("stalled result changed");

endmodule

FILE: dv/tb_stream_cipher_keystream_xor_unit.sv
// Self-checking testbench for the ChaCha20 keystream XOR unit.
module tb_stream_cipher_keystream_xor_unit;
    import ccx_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } msg_item_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;
    logic        valid_in;
    logic        stall_in;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        valid_out;
    logic        stall_out;
    logic [7:0]  out_byte;
    logic        out_last;

    stream_cipher_keystream_xor_unit dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .valid_in(valid_in), .stall_in(stall_in), .data_byte(data_byte),
        .last_byte(last_byte), .valid_out(valid_out), .stall_out(stall_out),
        .out_byte(out_byte), .out_last(out_last)
    );

    // Predictor copy of the registers and the cipher state.
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg;
    logic [31:0] nonce_hi_reg;
    logic [31:0] init_ctr_reg;
    logic [31:0] ks_words [16];
    logic [31:0] next_ctr;
    logic [5:0]  pos;
    logic        msg_start;

    msg_item_t pending_bytes [$];
    msg_item_t expected_out [$];
    int  error_count;
    int  cycle_count;
    int  gap_in;
    int  gap_out;

    localparam int CYCLE_LIMIT = 3000000;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 120);
    endfunction

    function automatic logic [31:0] rol32(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic qround(inout logic [31:0] w [16], input int a, int b, int c, int d);
        w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 16);
        w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 12);
        w[a] = w[a] + w[b]; w[d] = rol32(w[d] ^ w[a], 8);
        w[c] = w[c] + w[d]; w[b] = rol32(w[b] ^ w[c], 7);
    endtask

    task automatic make_keystream(input logic [31:0] ctr);
        logic [31:0] init [16];
        logic [31:0] w [16];
        init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
        for (int i = 0; i < 4; i++)
        begin
            init[4 + 2 * i] = key_reg[i][31:0];
            init[5 + 2 * i] = key_reg[i][63:32];
        end
        init[12] = ctr;
        init[13] = nonce_lo_reg[31:0];
        init[14] = nonce_lo_reg[63:32];
        init[15] = nonce_hi_reg;
        w = init;
        for (int r = 0; r < 10; r++)
        begin
            qround(w, 0, 4, 8, 12);
            qround(w, 1, 5, 9, 13);
            qround(w, 2, 6, 10, 14);
            qround(w, 3, 7, 11, 15);
            qround(w, 0, 5, 10, 15);
            qround(w, 1, 6, 11, 12);
            qround(w, 2, 7, 8, 13);
            qround(w, 3, 4, 9, 14);
        end
        for (int i = 0; i < 16; i++)
            ks_words[i] = w[i] + init[i];
    endtask

    task automatic predict_cipher_byte(input msg_item_t it);
        logic [31:0] ctr;
        msg_item_t res;
        if (pos == 6'd0)
        begin
            ctr = msg_start ? init_ctr_reg : next_ctr;
            make_keystream(ctr);
            next_ctr = ctr + 32'd1;
            msg_start = 1'b0;
        end
        res.data = it.data ^ ks_words[pos[5:2]][pos[1:0] * 8 +: 8];
        res.last = it.last;
        expected_out.push_back(res);
        if (it.last)
        begin
            pos = 6'd0;
            msg_start = 1'b1;
        end
        else
            pos = pos + 6'd1;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got, input logic [7:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
        error_count++;
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
        paddr = ADDR_W'(idx) << 3; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            REG_KEY0: key_reg[0] = val;
            REG_KEY1: key_reg[1] = val;
            REG_KEY2: key_reg[2] = val;
            REG_KEY3: key_reg[3] = val;
            REG_NONCE_LO: nonce_lo_reg = val;
            REG_NONCE_HI: nonce_hi_reg = val[31:0];
            REG_INIT_CTR: init_ctr_reg = val[31:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() != 0 || expected_out.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic queue_message(input int len, input int mode);
        msg_item_t it;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                1: it.data = 8'h00;
                2: it.data = 8'hff;
                default: it.data = 8'($urandom);
            endcase
            it.last = (i == len - 1);
            pending_bytes.push_back(it);
        end
    endtask

    // Driver: feeds items from the pending queue at falling edges with random gaps.
    // An item still shown with stall low has been taken, so it leaves the queue.
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_in <= 1'b0;
            data_byte <= 8'h00;
            last_byte <= 1'b0;
            gap_in <= 0;
        end
        else if (valid_in && stall_in)
        begin
            // Hold the stalled item.
        end
        else
        begin
            if (valid_in)
                void'(pending_bytes.pop_front());
            if (gap_in > 0)
            begin
                valid_in <= 1'b0;
                gap_in <= gap_in - 1;
            end
            else if (pending_bytes.size() > 0)
            begin
                msg_item_t nx;
                nx = pending_bytes[0];
                valid_in <= 1'b1;
                data_byte <= nx.data;
                last_byte <= nx.last;
                gap_in <= pick_gap();
            end
            else
                valid_in <= 1'b0;
        end
    end

    // The predictor runs when an item is taken at the rising edge.
    always @(posedge clk)
    begin
        msg_item_t acc;
        if (rst_n && valid_in && !stall_in)
        begin
            acc.data = data_byte;
            acc.last = last_byte;
            predict_cipher_byte(acc);
        end
    end

    // Monitor: checks results; the block after it drives the receiver stall.
    always @(posedge clk)
    begin
        msg_item_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && valid_out && !stall_out)
        begin
            if (expected_out.size() == 0)
            begin
                report_mismatch("unexpected result", out_byte, 8'h00);
            end
            else
            begin
                want = expected_out.pop_front();
                if (out_byte !== want.data)
                    report_mismatch("out_byte", out_byte, want.data);
                if (out_last !== want.last)
                    report_mismatch("out_last", {7'd0, out_last}, {7'd0, want.last});
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_out <= 1'b0;
            gap_out <= 0;
        end
        else if (gap_out > 0)
        begin
            stall_out <= 1'b1;
            gap_out <= gap_out - 1;
        end
        else
        begin
            stall_out <= 1'b0;
            gap_out <= pick_gap();
        end
    end

    initial
    begin
        int sent;
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        error_count = 0; cycle_count = 0;
        for (int i = 0; i < 4; i++)
            key_reg[i] = '0;
        nonce_lo_reg = '0; nonce_hi_reg = '0; init_ctr_reg = 32'd1;
        next_ctr = 32'd1; pos = '0; msg_start = 1'b1;
        for (int i = 0; i < 16; i++)
            ks_words[i] = '0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, zero and all-ones bytes, then the
        // RFC 8439 key and nonce with a counter wrap across a block boundary.
        queue_message(3, 1);
        queue_message(2, 2);
        wait_drained();
        reg_write(REG_KEY0, 64'h0706050403020100);
        reg_write(REG_KEY1, 64'h0f0e0d0c0b0a0908);
        reg_write(REG_KEY2, 64'h1716151413121110);
        reg_write(REG_KEY3, 64'h1f1e1d1c1b1a1918);
        reg_write(REG_NONCE_LO, 64'h4a00000000000000);
        reg_write(REG_NONCE_HI, 32'h00000000);
        reg_write(REG_INIT_CTR, 32'hffffffff);
        queue_message(80, 0);
        wait_drained();
        reg_write(REG_INIT_CTR, 32'h00000000);
        reg_write(REG_NONCE_HI, 32'hffffffff);
        queue_message(1, 2);
        wait_drained();

        sent = 0;
        while (sent < 970)
        begin
            int len;
            if (sent % 300 < 20)
            begin
                // Reconfigure between phases, sometimes to extremes.
                wait_drained();
                for (int r = 0; r < 7; r++)
                begin
                    logic [63:0] v;
                    case ($urandom_range(0, 3))
                        0: v = '0;
                        1: v = '1;
                        default: v = {$urandom, $urandom};
                    endcase
                    if ($urandom_range(0, 1))
                        reg_write(3'(r), v);
                end
            end
            len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20) : $urandom_range(60, 140);
            queue_message(len, 0);
            sent += len;
            while (pending_bytes.size() > 40)
                @(negedge clk);
        end
        wait_drained();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: filelist.f
src/ccx_pkg.sv
src/ccx_quarter.sv
src/ccx_regs.sv
src/stream_cipher_keystream_xor_unit.sv
dv/tb_stream_cipher_keystream_xor_unit.sv
